[sv/pcnt_pkg.sv]
// types, codes and constants shared by the people counter modules
`timescale 1ns / 1ps

package pcnt_pkg;

    // action codes of an input item
    localparam logic [2:0] ACT_ECHO_ONE = 3'd0;
    localparam logic [2:0] ACT_ECHO_TWO = 3'd1;
    localparam logic [2:0] ACT_COMMAND  = 3'd2;
    localparam logic [2:0] ACT_TICK     = 3'd3;
    localparam logic [2:0] ACT_EVALUATE = 3'd4;

    // command byte that arms or cancels a pass (ascii '1')
    localparam logic [7:0] CMD_ARM = 8'h31;

    // pass phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_ENTERING = 2'd1;
    localparam logic [1:0] PH_LEAVING  = 2'd2;
    localparam logic [1:0] PH_ARMED    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DIST_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_ALARM_LIMIT    = 2'd2;

    // reset values
    localparam logic [7:0]  RST_DIST_THRESHOLD = 8'd50;
    localparam logic [7:0]  RST_TIMEOUT_LIMIT  = 8'd100;
    localparam logic [15:0] RST_ALARM_LIMIT    = 16'd2;
    localparam logic [7:0]  RST_RANGE          = 8'd50;

    // distance = floor(diff * 17 / 1000), saturated at 255
    // diff at or above this gives at least 255
    localparam logic [15:0] DIST_SAT_DIFF = 16'd15059;
    // reciprocal of 1000 scaled by 2^28, exact for products below 2^28 / 544
    localparam logic [18:0] RECIP_M       = 19'd268436;
    localparam int          RECIP_SHIFT   = 28;
    localparam logic [7:0]  DIST_MAX      = 8'd255;

    localparam logic [7:0]  TICK_MAX      = 8'd255;
    localparam logic [15:0] PEOPLE_MAX    = 16'hffff;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] capture_value;
        logic [7:0]  command_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] person_count;
        logic [1:0]  phase;
        logic        crowd_alarm;
        logic [7:0]  distance_one;
        logic [7:0]  distance_two;
    } result_t;

    typedef struct packed {
        logic [7:0]  distance_threshold;
        logic [7:0]  timeout_limit;
        logic [15:0] alarm_limit;
    } cfg_t;

endpackage

[sv/pcnt_dist.sv]
// echo time difference to distance conversion
`timescale 1ns / 1ps

module pcnt_dist (
    input  logic [15:0] start_value,
    input  logic [15:0] end_value,
    output logic [7:0]  distance
);

    logic [15:0] diff;
    logic [20:0] scaled;
    logic [36:0] prod;

    always_comb
    begin
        if (end_value > start_value)
        begin
            diff = end_value - start_value;
        end
        else if (start_value > end_value)
        begin
            // timer wrapped between the edges
            diff = (16'hffff - start_value) + end_value;
        end
        else
        begin
            diff = 16'd0;
        end
    end

    // diff * 17 as shift and add
    assign scaled = {5'd0, diff} + {1'b0, diff, 4'd0};

    // below saturation scaled fits 18 bits
    assign prod = 37'(scaled[17:0]) * 37'(pcnt_pkg::RECIP_M);

    assign distance = (diff >= pcnt_pkg::DIST_SAT_DIFF) ? pcnt_pkg::DIST_MAX
                    : prod[pcnt_pkg::RECIP_SHIFT +: 8];

endmodule

[sv/pcnt_core.sv]
// counter state and per-item update logic
`timescale 1ns / 1ps

module pcnt_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  pcnt_pkg::item_t    item,
    input  pcnt_pkg::cfg_t     cfg,
    output pcnt_pkg::result_t  result
);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] people_reg, people_next;
    logic [7:0]  ticks_reg, ticks_next;
    logic        pend_one_reg, pend_one_next;
    logic [15:0] start_one_reg, start_one_next;
    logic        pend_two_reg, pend_two_next;
    logic [15:0] start_two_reg, start_two_next;
    logic [7:0]  range_one_reg, range_one_next;
    logic [7:0]  range_two_reg, range_two_next;

    logic [15:0] dist_start;
    logic [7:0]  dist_value;
    logic        det_one;
    logic        det_two;

    // one converter shared by both channels
    assign dist_start = (item.action == pcnt_pkg::ACT_ECHO_TWO) ? start_two_reg
                                                                : start_one_reg;

    pcnt_dist u_dist (
        .start_value (dist_start),
        .end_value   (item.capture_value),
        .distance    (dist_value)
    );

    assign det_one = range_one_reg < cfg.distance_threshold;
    assign det_two = range_two_reg < cfg.distance_threshold;

    always_comb
    begin
        phase_next     = phase_reg;
        people_next    = people_reg;
        ticks_next     = ticks_reg;
        pend_one_next  = pend_one_reg;
        start_one_next = start_one_reg;
        pend_two_next  = pend_two_reg;
        start_two_next = start_two_reg;
        range_one_next = range_one_reg;
        range_two_next = range_two_reg;

        unique case (item.action)
            pcnt_pkg::ACT_ECHO_ONE:
            begin
                if (!pend_one_reg)
                begin
                    start_one_next = item.capture_value;
                    pend_one_next  = 1'b1;
                end
                else
                begin
                    range_one_next = dist_value;
                    pend_one_next  = 1'b0;
                end
            end
            pcnt_pkg::ACT_ECHO_TWO:
            begin
                if (!pend_two_reg)
                begin
                    start_two_next = item.capture_value;
                    pend_two_next  = 1'b1;
                end
                else
                begin
                    range_two_next = dist_value;
                    pend_two_next  = 1'b0;
                end
            end
            pcnt_pkg::ACT_COMMAND:
            begin
                if (item.command_byte == pcnt_pkg::CMD_ARM)
                begin
                    ticks_next = 8'd0;
                    if (phase_reg == pcnt_pkg::PH_IDLE || phase_reg == pcnt_pkg::PH_ARMED)
                    begin
                        phase_next = pcnt_pkg::PH_ARMED;
                    end
                    else
                    begin
                        phase_next = pcnt_pkg::PH_IDLE;
                    end
                end
            end
            pcnt_pkg::ACT_TICK:
            begin
                if (ticks_reg != pcnt_pkg::TICK_MAX)
                begin
                    ticks_next = ticks_reg + 8'd1;
                end
            end
            pcnt_pkg::ACT_EVALUATE:
            begin
                // sensor one wins when both detect
                priority if (det_one)
                begin
                    ticks_next = 8'd0;
                    if (phase_reg == pcnt_pkg::PH_ARMED)
                    begin
                        phase_next = pcnt_pkg::PH_ENTERING;
                    end
                    else if (phase_reg == pcnt_pkg::PH_LEAVING)
                    begin
                        if (people_reg != 16'd0)
                        begin
                            people_next = people_reg - 16'd1;
                        end
                        phase_next = pcnt_pkg::PH_IDLE;
                    end
                end
                else if (det_two)
                begin
                    ticks_next = 8'd0;
                    if (phase_reg == pcnt_pkg::PH_IDLE)
                    begin
                        phase_next = pcnt_pkg::PH_LEAVING;
                    end
                    else if (phase_reg == pcnt_pkg::PH_ENTERING)
                    begin
                        if (people_reg != pcnt_pkg::PEOPLE_MAX)
                        begin
                            people_next = people_reg + 16'd1;
                        end
                        phase_next = pcnt_pkg::PH_IDLE;
                    end
                    else if (phase_reg == pcnt_pkg::PH_ARMED)
                    begin
                        phase_next = pcnt_pkg::PH_IDLE;
                    end
                end
                else if (ticks_reg > cfg.timeout_limit)
                begin
                    ticks_next = 8'd0;
                    phase_next = pcnt_pkg::PH_IDLE;
                end
            end
            default:
            begin
                // unused action codes leave the state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pcnt_pkg::PH_IDLE;
            people_reg    <= 16'd0;
            ticks_reg     <= 8'd0;
            pend_one_reg  <= 1'b0;
            start_one_reg <= 16'd0;
            pend_two_reg  <= 1'b0;
            start_two_reg <= 16'd0;
            range_one_reg <= pcnt_pkg::RST_RANGE;
            range_two_reg <= pcnt_pkg::RST_RANGE;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            people_reg    <= people_next;
            ticks_reg     <= ticks_next;
            pend_one_reg  <= pend_one_next;
            start_one_reg <= start_one_next;
            pend_two_reg  <= pend_two_next;
            start_two_reg <= start_two_next;
            range_one_reg <= range_one_next;
            range_two_reg <= range_two_next;
        end
    end

    // result shows the state after the item
    always_comb
    begin
        result.person_count = people_next;
        result.phase        = phase_next;
        result.crowd_alarm  = people_next > cfg.alarm_limit;
        result.distance_one = range_one_next;
        result.distance_two = range_two_next;
    end

endmodule

[sv/two_sensor_directional_people_counter_unit.sv]
// out_valid rises once an accepted item has passed the input register and then the result register
// throughput: one item per cycle, sustained while out_ready stays high
// a stalled output holds its item; the input register still frees when the result slot moves
// reset (rst_n low, async): count 0, phase idle, ranges 50, registers at 50/100/2
// config writes are always taken (cfg_ready high); index 3 is ignored
`timescale 1ns / 1ps

module two_sensor_directional_people_counter_unit (
    input  logic               clk,
    input  logic               rst_n,
    // item input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  pcnt_pkg::item_t    in_item,
    // result output channel
    output logic               out_valid,
    input  logic               out_ready,
    output pcnt_pkg::result_t  out_item,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // input stage
    logic              in_vld_reg;
    pcnt_pkg::item_t   in_item_reg;

    // result stage
    logic              out_vld_reg;
    pcnt_pkg::result_t out_item_reg;

    // configuration registers
    pcnt_pkg::cfg_t    cfg_reg;

    pcnt_pkg::result_t result;
    logic              step;
    logic              in_take;

    // the item in the input register moves on when the result slot is free or draining
    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;
    assign in_take  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    // state update and result for the item in the input register
    pcnt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (step)
            begin
                in_vld_reg <= 1'b0;
            end

            if (step)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_threshold <= pcnt_pkg::RST_DIST_THRESHOLD;
            cfg_reg.timeout_limit      <= pcnt_pkg::RST_TIMEOUT_LIMIT;
            cfg_reg.alarm_limit        <= pcnt_pkg::RST_ALARM_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcnt_pkg::CFG_DIST_THRESHOLD: cfg_reg.distance_threshold <= cfg_data[7:0];
                pcnt_pkg::CFG_TIMEOUT_LIMIT:  cfg_reg.timeout_limit      <= cfg_data[7:0];
                pcnt_pkg::CFG_ALARM_LIMIT:    cfg_reg.alarm_limit        <= cfg_data;
                default:
                begin
                    // no register at this index
                end
            endcase
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

endmodule

[dv/two_sensor_directional_people_counter_unit_tb.sv]
// testbench for the two sensor directional people counter unit
`timescale 1ns / 1ps

module two_sensor_directional_people_counter_unit_tb;

    // action codes the block must take and ignore
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    // register index that the block drops
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int REPORT_MAX    = 10;      // mismatches shown in full
    localparam int CYCLE_LIMIT   = 200000;  // watchdog, many times the slowest run
    localparam int SETTLE_CYCLES = 6;       // input and result register plus margin
    localparam int LONG_HOLD     = 80;      // receiver hold-off to back the block up

    // expected view of the counter, kept in step with accepted items
    class count_tracker;
        logic [7:0]  near_limit;
        logic [7:0]  tick_limit;
        logic [15:0] crowd_limit;
        logic [1:0]  phase;
        logic [15:0] people;
        logic [7:0]  ticks;
        logic        echo_open [2];
        logic [15:0] echo_start [2];
        logic [7:0]  echo_range [2];
        pcnt_pkg::result_t owed_reports [$];
        int          mismatches;

        function new();
            near_limit  = pcnt_pkg::RST_DIST_THRESHOLD;
            tick_limit  = pcnt_pkg::RST_TIMEOUT_LIMIT;
            crowd_limit = pcnt_pkg::RST_ALARM_LIMIT;
            phase       = pcnt_pkg::PH_IDLE;
            people      = '0;
            ticks       = '0;
            for (int i = 0; i < 2; i++)
            begin
                echo_open[i]  = 1'b0;
                echo_start[i] = '0;
                echo_range[i] = pcnt_pkg::RST_RANGE;
            end
            mismatches = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [15:0] data);
            case (idx)
                pcnt_pkg::CFG_DIST_THRESHOLD: near_limit = data[7:0];
                pcnt_pkg::CFG_TIMEOUT_LIMIT:  tick_limit = data[7:0];
                pcnt_pkg::CFG_ALARM_LIMIT:    crowd_limit = data;
                default: ;
            endcase
        endfunction

        // wrapped timer span to distance, saturating
        function logic [7:0] range_of(input logic [15:0] s, input logic [15:0] e);
            int unsigned span;
            int unsigned d;
            if (e > s)
                span = e - s;
            else if (s > e)
                span = 32'hffff - s + e;
            else
                span = 0;
            d = span * 17 / 1000;
            return (d > 255) ? pcnt_pkg::DIST_MAX : d[7:0];
        endfunction

        // direction machine, sensor one first
        function void run_evaluate();
            if (echo_range[0] < near_limit)
            begin
                ticks = '0;
                if (phase == pcnt_pkg::PH_ARMED)
                    phase = pcnt_pkg::PH_ENTERING;
                else if (phase == pcnt_pkg::PH_LEAVING)
                begin
                    if (people != 0)
                        people = people - 1'b1;
                    phase = pcnt_pkg::PH_IDLE;
                end
            end
            else if (echo_range[1] < near_limit)
            begin
                ticks = '0;
                if (phase == pcnt_pkg::PH_IDLE)
                    phase = pcnt_pkg::PH_LEAVING;
                else if (phase == pcnt_pkg::PH_ENTERING)
                begin
                    if (people != pcnt_pkg::PEOPLE_MAX)
                        people = people + 1'b1;
                    phase = pcnt_pkg::PH_IDLE;
                end
                else if (phase == pcnt_pkg::PH_ARMED)
                    phase = pcnt_pkg::PH_IDLE;
            end
            else if (ticks > tick_limit)
            begin
                ticks = '0;
                phase = pcnt_pkg::PH_IDLE;
            end
        endfunction

        function void note_event(input pcnt_pkg::item_t it);
            int                ch;
            pcnt_pkg::result_t r;
            case (it.action)
                pcnt_pkg::ACT_ECHO_ONE, pcnt_pkg::ACT_ECHO_TWO:
                begin
                    ch = (it.action == pcnt_pkg::ACT_ECHO_TWO) ? 1 : 0;
                    if (!echo_open[ch])
                    begin
                        echo_start[ch] = it.capture_value;
                        echo_open[ch]  = 1'b1;
                    end
                    else
                    begin
                        echo_range[ch] = range_of(echo_start[ch], it.capture_value);
                        echo_open[ch]  = 1'b0;
                    end
                end
                pcnt_pkg::ACT_COMMAND:
                begin
                    if (it.command_byte == pcnt_pkg::CMD_ARM)
                    begin
                        ticks = '0;
                        phase = (phase == pcnt_pkg::PH_IDLE || phase == pcnt_pkg::PH_ARMED)
                              ? pcnt_pkg::PH_ARMED : pcnt_pkg::PH_IDLE;
                    end
                end
                pcnt_pkg::ACT_TICK:
                begin
                    if (ticks != pcnt_pkg::TICK_MAX)
                        ticks = ticks + 1'b1;
                end
                pcnt_pkg::ACT_EVALUATE: run_evaluate();
                default: ;
            endcase
            r.person_count = people;
            r.phase        = phase;
            r.crowd_alarm  = (people > crowd_limit);
            r.distance_one = echo_range[0];
            r.distance_two = echo_range[1];
            owed_reports.push_back(r);
        endfunction

        function void check_result(input pcnt_pkg::result_t got);
            pcnt_pkg::result_t want;
            if (owed_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result count %0d phase %0d alarm %0b d1 %0d d2 %0d",
                             $time, got.person_count, got.phase, got.crowd_alarm,
                             got.distance_one, got.distance_two);
                return;
            end
            want = owed_reports.pop_front();
            if (got.person_count !== want.person_count || got.phase !== want.phase ||
                got.crowd_alarm !== want.crowd_alarm ||
                got.distance_one !== want.distance_one ||
                got.distance_two !== want.distance_two)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t: expected count %0d phase %0d alarm %0b d1 %0d d2 %0d, ",
                              "got count %0d phase %0d alarm %0b d1 %0d d2 %0d"},
                             $time, want.person_count, want.phase, want.crowd_alarm,
                             want.distance_one, want.distance_two,
                             got.person_count, got.phase, got.crowd_alarm,
                             got.distance_one, got.distance_two);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    pcnt_pkg::item_t   in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    pcnt_pkg::result_t out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;

    count_tracker counts;
    int           items_sent = 0;
    int           idle_pct = 0;      // sender gap chance per cycle
    int           stall_pct = 0;     // receiver stall chance per cycle
    int           holds_asked = 0;   // bumped by stimulus to request a long hold-off
    int           holds_served = 0;
    int           hold_left = 0;
    int           cycle_count = 0;

    two_sensor_directional_people_counter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("** two_sensor_directional_people_counter_unit: FAILED **");
                $finish;
            end
        end
    end

    // result side: check on handshake, then pick next ready value
    // values read right after the edge are the ones the block saw at that edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                counts.check_result(out_item);
            if (holds_asked != holds_served)
            begin
                holds_served = holds_asked;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                // long hold-off so the block backs up and drops in_ready
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic pcnt_pkg::item_t make_item(input logic [2:0] act,
                                                  input logic [15:0] cap,
                                                  input logic [7:0] cmd);
        pcnt_pkg::item_t it;
        it.action        = act;
        it.capture_value = cap;
        it.command_byte  = cmd;
        return it;
    endfunction

    // offer one item, hold it until taken, then maybe go quiet for a while
    // valid stays high across back-to-back items, so it is never dropped and raised in one step
    task automatic send_item(input pcnt_pkg::item_t it);
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        counts.note_event(it);
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // stop offering and wait for every owed result, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (counts.owed_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        counts.set_reg(idx, data);
    endtask

    // all registers, plus a write to the unused index that must change nothing
    // upper data bits of the byte registers carry noise
    task automatic program_regs(input logic [7:0] thr, input logic [7:0] tmo,
                                input logic [15:0] alarm);
        write_reg(pcnt_pkg::CFG_DIST_THRESHOLD, {8'($urandom), thr});
        write_reg(pcnt_pkg::CFG_TIMEOUT_LIMIT, {8'($urandom), tmo});
        write_reg(pcnt_pkg::CFG_ALARM_LIMIT, alarm);
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // one echo measurement on a channel, near or far of the current threshold
    // an open measurement is closed first so the pair lines up
    task automatic take_range(input int ch, input bit near);
        logic [2:0]  act;
        logic [15:0] s;
        int unsigned span;
        int unsigned lo;
        act = (ch == 1) ? pcnt_pkg::ACT_ECHO_TWO : pcnt_pkg::ACT_ECHO_ONE;
        if (counts.echo_open[ch])
            send_item(make_item(act, 16'($urandom), 8'($urandom)));
        lo = counts.near_limit * 59 + 59;
        if ($urandom_range(0, 9) == 0)
            span = $urandom_range(0, 65535);
        else if (near)
            span = $urandom_range(0, counts.near_limit * 58);
        else
            span = $urandom_range(lo, (lo > 20000) ? lo : 20000);
        s = 16'($urandom);
        send_item(make_item(act, s, 8'($urandom)));
        send_item(make_item(act, s + 16'(span), 8'($urandom)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(make_item(pcnt_pkg::ACT_TICK, 16'($urandom), 8'($urandom)));
    endtask

    task automatic send_evaluate();
        send_item(make_item(pcnt_pkg::ACT_EVALUATE, 16'($urandom), 8'($urandom)));
    endtask

    task automatic send_arm();
        send_item(make_item(pcnt_pkg::ACT_COMMAND, 16'($urandom), pcnt_pkg::CMD_ARM));
    endtask

    // about a third whole passes in either direction with random timing values,
    // the rest single events and plain noise
    task automatic play_scenario();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            // entry: arm, sensor one, then sensor two
            send_arm();
            take_range(0, 1);
            take_range(1, 0);
            send_evaluate();
            if ($urandom_range(0, 4) == 0)
                send_ticks($urandom_range(1, 4));
            take_range(0, 0);
            take_range(1, 1);
            send_evaluate();
        end
        else if (pick < 36)
        begin
            // exit: sensor two, then sensor one
            take_range(0, 0);
            take_range(1, 1);
            send_evaluate();
            if ($urandom_range(0, 4) == 0)
                send_ticks($urandom_range(1, 4));
            take_range(1, 0);
            take_range(0, 1);
            send_evaluate();
        end
        else if (pick < 48)
            take_range($urandom_range(0, 1), 1'($urandom));
        else if (pick < 58)
            send_item(make_item(pcnt_pkg::ACT_COMMAND, 16'($urandom),
                                ($urandom_range(0, 99) < 60) ? pcnt_pkg::CMD_ARM
                                                             : 8'($urandom)));
        else if (pick < 68)
        begin
            n = $urandom_range(1, 6);
            if (counts.tick_limit < 12 && $urandom_range(0, 3) == 0)
                n = counts.tick_limit + 2;
            send_ticks(n);
        end
        else if (pick < 80)
            send_evaluate();
        else
            send_item(make_item(3'($urandom), 16'($urandom), 8'($urandom)));
    endtask

    task automatic run_random(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count)
            play_scenario();
    endtask

    initial
    begin
        counts = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset register values, no idling
        send_evaluate();                                           // nothing detected at reset
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'hffff, 8'h00));
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h0000, 8'hff));  // wrap that lands on zero
        send_item(make_item(pcnt_pkg::ACT_ECHO_TWO, 16'h1234, 8'h31));
        send_item(make_item(pcnt_pkg::ACT_ECHO_TWO, 16'h1234, 8'h31));  // equal captures
        send_evaluate();                                           // sensor one seen while idle
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h0000, 8'h00));
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'hffff, 8'h00));  // full span, saturates
        send_item(make_item(pcnt_pkg::ACT_COMMAND, 16'hffff, pcnt_pkg::CMD_ARM));
        send_item(make_item(pcnt_pkg::ACT_COMMAND, 16'h0000, 8'hff));   // other bytes do nothing
        send_item(make_item(pcnt_pkg::ACT_COMMAND, 16'hffff, 8'h30));
        send_evaluate();                                   // armed, only sensor two: back to idle
        send_item(make_item(pcnt_pkg::ACT_COMMAND, 16'h0000, pcnt_pkg::CMD_ARM));
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h0100, 8'h00));
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h034e, 8'h00));  // distance 10
        send_evaluate();                                           // armed to entering
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h8000, 8'h00));
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h970c, 8'h00));  // distance 100
        send_evaluate();                                           // entry counted
        send_evaluate();                                           // idle to leaving
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h0100, 8'h00));
        send_item(make_item(pcnt_pkg::ACT_ECHO_ONE, 16'h034e, 8'h00));
        send_evaluate();                                           // exit counted
        send_item(make_item(ACT_SPARE_5, 16'hffff, 8'hff));
        send_item(make_item(ACT_SPARE_6, 16'h0000, 8'h00));
        send_item(make_item(ACT_SPARE_7, 16'hffff, 8'hff));
        send_ticks(1);
        drain();

        // top threshold, zero timeout and alarm; receiver backs the block up
        program_regs(8'd255, 8'd0, 16'd0);
        holds_asked++;
        run_random(100);
        drain();

        // nothing detects; tick counter runs into saturation above the top timeout
        program_regs(8'd0, 8'd254, 16'd65535);
        idle_pct = 85;
        send_arm();
        send_ticks(256);
        send_evaluate();
        run_random(10);
        drain();

        // mid settings, receiver stalling
        program_regs(8'($urandom_range(30, 120)), 8'($urandom_range(0, 10)),
                     16'($urandom_range(0, 4)));
        idle_pct  = 0;
        stall_pct = 85;
        run_random(110);
        drain();

        // both sides idling lightly
        program_regs(8'($urandom_range(20, 200)), 8'($urandom_range(0, 254)),
                     16'($urandom_range(0, 3)));
        idle_pct  = 12;
        stall_pct = 12;
        run_random(110);
        drain();

        // back to reset values, full rate
        program_regs(pcnt_pkg::RST_DIST_THRESHOLD, pcnt_pkg::RST_TIMEOUT_LIMIT,
                     pcnt_pkg::RST_ALARM_LIMIT);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(80);
        drain();

        if (counts.mismatches == 0 && counts.owed_reports.size() == 0)
            $display("** two_sensor_directional_people_counter_unit: PASSED **");
        else
            $display("** two_sensor_directional_people_counter_unit: FAILED **");
        $finish;
    end

endmodule
